>>> hw/rtl/ddmc_pkg.sv
package ddmc_pkg;

	localparam int FRAC_BITS_DEF = 16;

	localparam logic [2:0] REG_MOVE_MODE    = 3'd0;
	localparam logic [2:0] REG_MOVE_AMOUNT  = 3'd1;
	localparam logic [2:0] REG_ARC_DIAMETER = 3'd2;
	localparam logic [2:0] REG_WHEEL_BASE   = 3'd3;
	localparam logic [2:0] REG_MAX_VELOCITY = 3'd4;

	localparam logic [1:0] MODE_STRAIGHT  = 2'd0;
	localparam logic [1:0] MODE_ARC_LEFT  = 2'd1;
	localparam logic [1:0] MODE_ARC_RIGHT = 2'd2;
	localparam logic [1:0] MODE_ROTATE    = 2'd3;

	localparam logic REQ_START = 1'b0;
	localparam logic REQ_TICK  = 1'b1;

	typedef struct packed {
		logic               req_type;
		logic signed [31:0] left_travel;
		logic signed [31:0] right_travel;
		logic signed [31:0] heading;
	} req_t;

	typedef struct packed {
		logic signed [31:0] left_speed;
		logic signed [31:0] right_speed;
		logic               move_done;
	} rsp_t;

endpackage

>>> hw/rtl/diff_drive_move_controller_core.sv
// Move controller for a differential-drive base in signed fixed point with
// FRAC_BITS fraction bits. A start transaction latches wheel and heading goals
// from the measurements and the configured mode; a tick transaction returns
// the two wheel velocity commands and a done flag, one result per item. One
// item is worked on at a time: the products go through a shift-add multiplier
// that retires one multiplier bit per cycle and the arc ratio through a
// restoring divider that retires one quotient bit per cycle. Configuration
// writes are always accepted (cfg_ready is high) and must be made while no
// item is in flight.
module diff_drive_move_controller_core #(
	parameter int FRAC_BITS = ddmc_pkg::FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  ddmc_pkg::req_t   in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output ddmc_pkg::rsp_t   out_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [2:0]       cfg_index,
	input  logic [31:0]      cfg_data
);

	localparam int AW  = FRAC_BITS + 34;
	localparam int ACC = AW + 32;
	localparam int LW  = 35;
	localparam int CW  = $clog2(AW + 1);
	localparam int TW  = FRAC_BITS - 5;
	localparam longint ONE_Q = 64'd1 << FRAC_BITS;
	localparam logic [30:0] STEP_Q = 31'((ONE_Q * 5 + 50) / 100);
	localparam logic [TW-1:0] TOL_D = TW'((ONE_Q + 50) / 100);
	localparam logic [33:0] TOL_A = 34'((ONE_Q * 87266 + 5000000) / 10000000);
	localparam logic [LW-1:0] CAP_GOAL = {LW{1'b1}} >> 1;
	localparam logic [LW-1:0] CAP_POS  = LW'(32'h7fff_ffff);
	localparam logic [LW-1:0] CAP_NEG  = LW'(33'h0_8000_0000);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PREP = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_POST = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;

	function automatic logic [33:0] absv(input logic signed [33:0] v);
		return v[33] ? 34'(-v) : 34'(v);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
		if (v > 41'sd2147483647) begin
			return 32'sh7fff_ffff;
		end else if (v < -41'sd2147483648) begin
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	logic [2:0]          state_q;
	logic                phase_q;
	ddmc_pkg::req_t      in_q;
	logic [1:0]          mode_q;
	logic signed [31:0]  amount_q;
	logic [30:0]         dia_q, wb_q, maxv_q, ramp_q;
	logic signed [31:0]  goal_l_q, goal_r_q, goal_h_q;
	logic [AW-1:0]       mul_a_q;
	logic [31:0]         mul_b_q;
	logic [ACC-1:0]      acc_q;
	logic [LW-1:0]       lim_q, si_q;
	logic                mul_neg_q, si_neg_q, rneg_q;
	logic [CW-1:0]       cnt_q;
	logic [33:0]         rem_q;
	logic signed [31:0]  res_l_q, res_r_q;
	logic                res_done_q;
	logic                out_valid_q;
	ddmc_pkg::rsp_t      out_q;

	logic signed [33:0]  dl, dr, mean, diff, mx, mn, dsum;
	logic signed [30:0]  inner;
	logic [30:0]         outer;
	logic [AW:0]         mul_sum;
	logic [ACC-1:0]      mul_q;
	logic [LW-1:0]       mul_m;
	logic [34:0]         div_sh;
	logic                div_ge;
	logic [33:0]         adl, adr;
	logic [2*TW:0]       sq_sum;
	logic                dist_ok;
	logic signed [40:0]  m_signed, dlm, drm, sgoal;
	logic signed [31:0]  scaled;
	logic                base_neg, out_free;

	assign dl   = 34'(goal_l_q) - 34'(in_q.left_travel);
	assign dr   = 34'(goal_r_q) - 34'(in_q.right_travel);
	assign diff = 34'(in_q.heading) - 34'(goal_h_q);
	assign dsum = dl + dr;
	// Rounds the halved sum toward zero.
	assign mean = (dsum + $signed(34'(dsum[33]))) >>> 1;
	assign mx   = (dl < dr) ? dr : dl;
	assign mn   = (dl < dr) ? dl : dr;
	assign inner = $signed({1'b0, dia_q[30:1]}) - $signed({1'b0, wb_q[30:1]});
	assign outer = {1'b0, dia_q[30:1]} + {1'b0, wb_q[30:1]};

	assign mul_sum = {1'b0, acc_q[ACC-1:32]} + (mul_b_q[0] ? {1'b0, mul_a_q} : '0);
	assign mul_q   = acc_q >> FRAC_BITS;
	assign mul_m   = (mul_q > ACC'(lim_q)) ? lim_q : mul_q[LW-1:0];
	assign m_signed = mul_neg_q ? -$signed({6'b0, mul_m}) : $signed({6'b0, mul_m});
	assign base_neg = mul_neg_q && (mul_m != '0);

	assign div_sh = {rem_q, mul_a_q[AW-1]};
	assign div_ge = div_sh >= {1'b0, absv(mx)};

	assign adl = absv(dl);
	assign adr = absv(dr);
	assign sq_sum = (2*TW+1)'(adl[TW-1:0] * adl[TW-1:0]) + (2*TW+1)'(adr[TW-1:0] * adr[TW-1:0]);
	assign dist_ok = (adl <= 34'(TOL_D)) && (adr <= 34'(TOL_D))
		&& (sq_sum <= (2*TW+1)'(TOL_D * TOL_D));

	assign dlm = 41'((41'(dl) - 41'(mean)) * 41'sd50);
	assign drm = 41'((41'(dr) - 41'(mean)) * 41'sd50);
	assign scaled = mul_neg_q ? 32'(-$signed({1'b0, mul_m})) : 32'(mul_m);
	assign sgoal = si_neg_q ? -$signed({6'b0, si_q}) : $signed({6'b0, si_q});

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= ddmc_pkg::MODE_STRAIGHT;
			amount_q <= '0;
			dia_q    <= '0;
			wb_q     <= '0;
			maxv_q   <= 31'd65536;
		end else if (cfg_valid) begin
			case (cfg_index)
				ddmc_pkg::REG_MOVE_MODE:    mode_q   <= cfg_data[1:0];
				ddmc_pkg::REG_MOVE_AMOUNT:  amount_q <= cfg_data;
				ddmc_pkg::REG_ARC_DIAMETER: dia_q    <= cfg_data[30:0];
				ddmc_pkg::REG_WHEEL_BASE:   wb_q     <= cfg_data[30:0];
				ddmc_pkg::REG_MAX_VELOCITY: maxv_q   <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= 1'b0;
			cnt_q       <= '0;
			goal_l_q    <= '0;
			goal_r_q    <= '0;
			goal_h_q    <= '0;
			ramp_q      <= STEP_Q;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						in_q    <= in_data;
						phase_q <= 1'b0;
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					acc_q      <= '0;
					cnt_q      <= '0;
					res_l_q    <= '0;
					res_r_q    <= '0;
					res_done_q <= 1'b0;
					if (in_q.req_type == ddmc_pkg::REQ_START) begin
						if (mode_q == ddmc_pkg::MODE_STRAIGHT) begin
							goal_l_q <= sat32(41'(in_q.left_travel) + 41'(amount_q));
							goal_r_q <= sat32(41'(in_q.right_travel) + 41'(amount_q));
							goal_h_q <= in_q.heading;
							state_q  <= S_FIN;
						end else if (mode_q == ddmc_pkg::MODE_ROTATE) begin
							goal_l_q <= in_q.left_travel;
							goal_r_q <= in_q.right_travel;
							goal_h_q <= sat32(41'(in_q.heading) + 41'(amount_q));
							state_q  <= S_FIN;
						end else begin
							goal_l_q  <= in_q.left_travel;
							goal_r_q  <= in_q.right_travel;
							goal_h_q  <= in_q.heading;
							mul_a_q   <= AW'(absv(34'(inner)));
							mul_b_q   <= 32'(absv(34'(amount_q)));
							lim_q     <= CAP_GOAL;
							mul_neg_q <= inner[30] != amount_q[31];
							state_q   <= S_MUL;
						end
					end else begin
						state_q <= S_MUL;
						if (mode_q == ddmc_pkg::MODE_STRAIGHT) begin
							mul_a_q   <= AW'(40'(absv(mean)) * 40'd15);
							mul_b_q   <= 32'(ramp_q);
							lim_q     <= LW'(ramp_q);
							mul_neg_q <= mean[33];
						end else if (mode_q == ddmc_pkg::MODE_ROTATE) begin
							mul_a_q   <= AW'(absv(diff));
							mul_b_q   <= 32'(ramp_q);
							lim_q     <= LW'(ramp_q);
							mul_neg_q <= diff[33];
						end else begin
							mul_a_q   <= AW'(40'(absv(mx)) * 40'd10);
							mul_b_q   <= 32'(ramp_q);
							lim_q     <= LW'(maxv_q);
							mul_neg_q <= mx[33];
						end
					end
				end
				S_MUL: begin
					acc_q   <= {mul_sum, acc_q[31:1]};
					mul_b_q <= mul_b_q >> 1;
					cnt_q   <= cnt_q + 1'b1;
					if (cnt_q == CW'(31)) begin
						state_q <= S_POST;
					end
				end
				S_POST: begin
					acc_q   <= '0;
					cnt_q   <= '0;
					if (in_q.req_type == ddmc_pkg::REQ_START) begin
						if (!phase_q) begin
							si_q      <= mul_m;
							si_neg_q  <= mul_neg_q;
							mul_a_q   <= AW'(outer);
							mul_neg_q <= amount_q[31];
							phase_q   <= 1'b1;
							mul_b_q   <= 32'(absv(34'(amount_q)));
							state_q   <= S_MUL;
						end else if (mode_q == ddmc_pkg::MODE_ARC_LEFT) begin
							goal_l_q <= sat32(41'(in_q.left_travel) + sgoal);
							goal_r_q <= sat32(41'(in_q.right_travel) + m_signed);
							state_q  <= S_FIN;
						end else begin
							goal_r_q <= sat32(41'(in_q.right_travel) + sgoal);
							goal_l_q <= sat32(41'(in_q.left_travel) + m_signed);
							state_q  <= S_FIN;
						end
					end else if (mode_q == ddmc_pkg::MODE_STRAIGHT) begin
						res_l_q    <= sat32(m_signed + dlm);
						res_r_q    <= sat32(m_signed + drm);
						res_done_q <= dist_ok;
						state_q    <= S_FIN;
					end else if (mode_q == ddmc_pkg::MODE_ROTATE) begin
						res_l_q    <= 32'(m_signed);
						res_r_q    <= 32'(-m_signed);
						res_done_q <= absv(diff) <= TOL_A;
						state_q    <= S_FIN;
					end else if (!phase_q) begin
						// Arc base speed is done; the inner wheel gets ratio times base.
						res_done_q <= dist_ok;
						phase_q    <= 1'b1;
						mul_b_q    <= 32'(mul_m);
						if (mode_q == ddmc_pkg::MODE_ARC_LEFT) begin
							res_r_q <= 32'(m_signed);
						end else begin
							res_l_q <= 32'(m_signed);
						end
						if (mx != '0) begin
							rneg_q  <= mn[33] != mx[33];
							si_neg_q <= base_neg;
							mul_a_q <= AW'(absv(mn)) << FRAC_BITS;
							rem_q   <= '0;
							state_q <= S_DIV;
						end else begin
							mul_a_q   <= AW'(ONE_Q);
							mul_neg_q <= base_neg;
							lim_q     <= base_neg ? CAP_NEG : CAP_POS;
							state_q   <= S_MUL;
						end
					end else if (mode_q == ddmc_pkg::MODE_ARC_LEFT) begin
						res_l_q <= scaled;
						state_q <= S_FIN;
					end else begin
						res_r_q <= scaled;
						state_q <= S_FIN;
					end
				end
				S_DIV: begin
					rem_q   <= div_ge ? 34'(div_sh - {1'b0, absv(mx)}) : div_sh[33:0];
					mul_a_q <= {mul_a_q[AW-2:0], div_ge};
					if (cnt_q == CW'(AW - 1)) begin
						cnt_q     <= '0;
						mul_neg_q <= rneg_q != si_neg_q;
						lim_q     <= (rneg_q != si_neg_q) ? CAP_NEG : CAP_POS;
						state_q   <= S_MUL;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_q.left_speed     <= res_l_q;
						out_q.right_speed    <= res_r_q;
						out_q.move_done      <= res_done_q;
						state_q              <= S_IDLE;
						if (in_q.req_type == ddmc_pkg::REQ_START) begin
							ramp_q <= STEP_Q;
						end else if (32'(ramp_q) + 32'(STEP_Q) > 32'(maxv_q)) begin
							ramp_q <= maxv_q;
						end else begin
							ramp_q <= ramp_q + STEP_Q;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == S_FIN)
		else $error("result appeared outside the finish step");
	a_accept_prep: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == S_PREP)
		else $error("accepted transaction did not start work");
	a_mul_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MUL |-> cnt_q < CW'(32))
		else $error("multiplier ran past its last bit");
`endif

endmodule
